FILE: hdl/nscl_pkg.sv
// Package for the seed cluster labeler: sizes, codes, state and shared types.
package nscl_pkg;

  localparam int NumPoints    = 4096;
  localparam int MaxNeighbors = 8;
  localparam int MaxLabels    = 4096;

  localparam int PtW   = $clog2(NumPoints);
  localparam int NbSelW = $clog2(MaxNeighbors);
  localparam int LabW  = 12;
  localparam int CntW  = 13;
  localparam int KW    = 4;

  // Number of placed-map copies: one per neighbour lane plus one for the point.
  localparam int NumLanes = MaxNeighbors + 1;

  // Operation codes of an input word.
  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Kinds of result word.
  localparam logic KIND_LABEL  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Register indexes of the configuration port.
  localparam logic CFG_K    = 1'b0;
  localparam logic CFG_DROP = 1'b1;

  // Finish report status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_NO_MAIN   = 2'd2;
  localparam logic [1:0] ST_TOO_TIGHT = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_LABEL,
    S_LRESP,
    S_SEED
  } state_e;

  // What the merging stage reports about the neighbour lanes.
  typedef struct packed {
    logic              any;
    logic [NbSelW-1:0] first;
  } merge_t;

endpackage

FILE: hdl/nscl_lane.sv
// One lane: a private copy of the placed map, read at the lane's own index.
module nscl_lane
  import nscl_pkg::*;
(
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [PtW-1:0] waddr_i,
  input  logic           wdata_i,
  input  logic [PtW-1:0] raddr_i,
  input  logic           used_i,
  output logic           hit_o
);

  logic placed_mem [NumPoints];
  logic rd_q;

  // Shared write, private read; read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      placed_mem[waddr_i] <= wdata_i;
    end
    rd_q <= placed_mem[raddr_i];
  end

  // A lane beyond the list length never reports a hit.
  assign hit_o = rd_q & used_i;

endmodule

FILE: hdl/nscl_merge.sv
// Merging stage: finds the first neighbour lane that reports a placed point.
module nscl_merge
  import nscl_pkg::*;
(
  input  logic [MaxNeighbors-1:0] hits_i,
  output merge_t                  merge_o
);

  // Priority pick, the lowest-numbered lane wins.
  always_comb begin
    merge_o.any   = |hits_i;
    merge_o.first = '0;
    for (int i = MaxNeighbors - 1; i >= 0; i--) begin
      if (hits_i[i]) begin
        merge_o.first = NbSelW'(i);
      end
    end
  end

endmodule

FILE: hdl/nng_seed_cluster_labeler_top.sv
// Top level of the seed cluster labeler: control, label store and result register.
// A point word is decided in steps: accept, lane lookup, then merge and decide.
// A seed then gives k result words, one per cycle while the result register is free to take them.
// A copied neighbour label adds the S_LABEL and S_LRESP states for the label store read.
// After reset the placed maps are swept clear; no word is taken then.
// Configuration writes are taken at any time, including during the sweep.
module nng_seed_cluster_labeler_top
  import nscl_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [KW-1:0]  cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           operation_i,
  input  logic [11:0]    point_i,
  input  logic           in_main_set_i,
  input  logic           list_cut_short_i,
  input  logic [11:0]    neighbor_0_i,
  input  logic [11:0]    neighbor_1_i,
  input  logic [11:0]    neighbor_2_i,
  input  logic [11:0]    neighbor_3_i,
  input  logic [11:0]    neighbor_4_i,
  input  logic [11:0]    neighbor_5_i,
  input  logic [11:0]    neighbor_6_i,
  input  logic [11:0]    neighbor_7_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           kind_o,
  output logic [11:0]    target_point_o,
  output logic [11:0]    label_o,
  output logic           label_missing_o,
  output logic [1:0]     status_o,
  output logic [12:0]    cluster_count_o,
  output logic           last_o
);

  state_e state_q, state_d;

  // Configuration registers.
  logic [KW-1:0] k_cfg_q;
  logic          drop_q;

  // Latched input word.
  logic                            op_q, main_q, cut_q;
  logic [PtW-1:0]                  pt_q;
  logic [MaxNeighbors-1:0][PtW-1:0] nb_q;
  logic [KW-1:0]                   k_q;
  logic [KW-1:0]                   k_eff;

  // Running state.
  logic [CntW-1:0]   next_label_q, next_label_d;
  logic              searched_q, searched_d;
  logic              overflow_q, overflow_d;
  logic [PtW-1:0]    clr_q;
  logic [KW-1:0]     cnt_q, cnt_d;
  logic              pt_hit_q, pt_hit_d;
  logic [LabW-1:0]   lab_q, lab_d;
  logic [NbSelW-1:0] first_q, first_d;

  // Result register.
  logic            ovalid_q;
  logic            okind_q, omiss_q, olast_q;
  logic [11:0]     otgt_q, olab_q;
  logic [1:0]      ost_q;
  logic [12:0]     ocnt_q;
  logic            load;
  logic            nkind, nmiss, nlast;
  logic [11:0]     ntgt, nlab;
  logic [1:0]      nst;
  logic            slot_free;

  // Memory write and lane signals.
  logic              mem_we, lab_we;
  logic [PtW-1:0]    mem_waddr;
  logic              mem_wdata;
  logic [NumLanes-1:0] hits;
  logic              pt_placed;
  merge_t            merge;
  logic [LabW-1:0]   label_mem [NumPoints];
  logic [LabW-1:0]   label_rd_q;
  logic [PtW-1:0]    seed_tgt;

  assign in_ready_o = (state_q == S_IDLE);
  assign slot_free  = !ovalid_q || out_ready_i;

  // Clamp the list length to the supported range.
  always_comb begin
    if (k_cfg_q < KW'(2)) begin
      k_eff = KW'(2);
    end else if (k_cfg_q > KW'(MaxNeighbors)) begin
      k_eff = KW'(MaxNeighbors);
    end else begin
      k_eff = k_cfg_q;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q <= KW'(2);
      drop_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_K:    k_cfg_q <= cfg_data_i;
        CFG_DROP: drop_q  <= cfg_data_i[0];
        default:  ;
      endcase
    end
  end

  // Capture the input word.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= operation_i;
      pt_q    <= point_i;
      main_q  <= in_main_set_i;
      cut_q   <= list_cut_short_i;
      k_q     <= k_eff;
      nb_q[0] <= neighbor_0_i;
      nb_q[1] <= neighbor_1_i;
      nb_q[2] <= neighbor_2_i;
      nb_q[3] <= neighbor_3_i;
      nb_q[4] <= neighbor_4_i;
      nb_q[5] <= neighbor_5_i;
      nb_q[6] <= neighbor_6_i;
      nb_q[7] <= neighbor_7_i;
    end
  end

  // Neighbour lanes plus the lane that looks up the point itself.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    logic [PtW-1:0] raddr;
    logic           used;
    if (g < MaxNeighbors) begin : g_nb
      assign raddr = nb_q[g];
      assign used  = (KW'(g) < k_q);
    end else begin : g_pt
      assign raddr = pt_q;
      assign used  = 1'b1;
    end
    nscl_lane u_lane (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .waddr_i (mem_waddr),
      .wdata_i (mem_wdata),
      .raddr_i (raddr),
      .used_i  (used),
      .hit_o   (hits[g])
    );
  end

  assign pt_placed = hits[NumLanes-1];

  nscl_merge u_merge (
    .hits_i  (hits[MaxNeighbors-1:0]),
    .merge_o (merge)
  );

  // Label store, read at the first placed neighbour.
  always_ff @(posedge clk_i) begin
    if (lab_we) begin
      label_mem[mem_waddr] <= lab_q;
    end
    label_rd_q <= label_mem[nb_q[first_q]];
  end

  // Seed target: the listed neighbours, then the point or the last neighbour.
  assign seed_tgt = (cnt_q < k_q - KW'(1)) ? nb_q[cnt_q[NbSelW-1:0]] :
                    (pt_hit_q ? nb_q[cnt_q[NbSelW-1:0]] : pt_q);

  // Sequencer: next state, memory writes and result loads.
  always_comb begin
    state_d      = state_q;
    next_label_d = next_label_q;
    searched_d   = searched_q;
    overflow_d   = overflow_q;
    cnt_d        = cnt_q;
    pt_hit_d     = pt_hit_q;
    lab_d        = lab_q;
    first_d      = first_q;
    mem_we       = 1'b0;
    lab_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = 1'b0;
    load         = 1'b0;
    nkind        = KIND_LABEL;
    ntgt         = pt_q;
    nlab         = '0;
    nmiss        = 1'b1;
    nst          = ST_OK;
    nlast        = 1'b1;
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (op_q == OP_FINISH) begin
          nkind = KIND_REPORT;
          ntgt  = '0;
          nmiss = 1'b0;
          if (overflow_q) begin
            nst = ST_OVERFLOW;
          end else if (next_label_q == '0) begin
            nst = searched_q ? ST_TOO_TIGHT : ST_NO_MAIN;
          end
          if (slot_free) begin
            load    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (overflow_q || pt_placed) begin
          state_d = S_IDLE;
        end else if (!main_q) begin
          if (slot_free) begin
            load    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (cut_q || (merge.any && drop_q)) begin
          if (slot_free) begin
            load       = 1'b1;
            searched_d = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (merge.any) begin
          searched_d = 1'b1;
          first_d    = merge.first;
          state_d    = S_LABEL;
        end else if (next_label_q >= CntW'(MaxLabels)) begin
          searched_d = 1'b1;
          overflow_d = 1'b1;
          state_d    = S_IDLE;
        end else begin
          searched_d   = 1'b1;
          lab_d        = next_label_q[LabW-1:0];
          next_label_d = next_label_q + CntW'(1);
          cnt_d        = '0;
          pt_hit_d     = 1'b0;
          state_d      = S_SEED;
        end
      end
      S_LABEL: begin
        state_d = S_LRESP;
      end
      S_LRESP: begin
        nmiss = 1'b0;
        nlab  = label_rd_q;
        if (slot_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SEED: begin
        ntgt  = seed_tgt;
        nlab  = lab_q;
        nmiss = 1'b0;
        nlast = (cnt_q == k_q - KW'(1));
        if (slot_free) begin
          load      = 1'b1;
          mem_we    = 1'b1;
          lab_we    = 1'b1;
          mem_waddr = seed_tgt;
          mem_wdata = 1'b1;
          cnt_d     = cnt_q + KW'(1);
          if (seed_tgt == pt_q) begin
            pt_hit_d = 1'b1;
          end
          if (nlast) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      next_label_q <= '0;
      searched_q   <= 1'b0;
      overflow_q   <= 1'b0;
      cnt_q        <= '0;
      pt_hit_q     <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_label_q <= next_label_d;
      searched_q   <= searched_d;
      overflow_q   <= overflow_d;
      cnt_q        <= cnt_d;
      pt_hit_q     <= pt_hit_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + PtW'(1);
      end
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lab_q   <= lab_d;
    first_q <= first_d;
    if (load) begin
      okind_q <= nkind;
      otgt_q  <= ntgt;
      olab_q  <= nlab;
      omiss_q <= nmiss;
      ost_q   <= nst;
      ocnt_q  <= next_label_d;
      olast_q <= nlast;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign kind_o          = okind_q;
  assign target_point_o  = otgt_q;
  assign label_o         = olab_q;
  assign label_missing_o = omiss_q;
  assign status_o        = ost_q;
  assign cluster_count_o = ocnt_q;
  assign last_o          = olast_q;

  // The seed counter stays within the list length.
  a_seed_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEED) |-> (cnt_q < k_q))
    else $error("seed counter ran past the list length");

  // No word is taken while the placed maps are being swept.
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("word accepted during the clearing sweep");

  // The overflow error is sticky.
  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |=> overflow_q)
    else $error("overflow error cleared");

  // The label counter never passes the label limit.
  a_label_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_label_q <= CntW'(MaxLabels))
    else $error("label counter beyond limit");

endmodule
